// ===== rtl/core/i2cbr_pkg.sv =====
// Package for the I2C bus recovery sequencer: phase codes, register indexes,
// configuration and result types, reset values. No dependencies.
`timescale 1ns / 1ps

package i2cbr_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0] HalfPeriodReset = 16'd5;
  localparam logic [CountW-1:0] ReqHighReset    = 8'd10;
  localparam logic [TimerW-1:0] SettleReset     = 16'd10000;
  localparam logic [CountW-1:0] CountMax        = 8'd255;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HOLD    = 4'd1,
    PH_UNLK_HI = 4'd2,
    PH_UNLK_LO = 4'd3,
    PH_STOP1_A = 4'd4,
    PH_STOP1_B = 4'd5,
    PH_CLK_HI  = 4'd6,
    PH_CLK_LO  = 4'd7,
    PH_STOP2_A = 4'd8,
    PH_STOP2_B = 4'd9,
    PH_STOP2_C = 4'd10,
    PH_SETTLE  = 4'd11,
    PH_READY   = 4'd12
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_REQ_HIGH    = 2'd1,
    CFG_SETTLE      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef struct packed {
    logic [TimerW-1:0] half_period;
    logic [CountW-1:0] req_high;
    logic [TimerW-1:0] settle;
  } cfg_t;

  typedef struct packed {
    logic scl_released;
    logic sda_released;
    logic pins_to_controller;
    logic busy;
    logic done;
  } result_t;

endpackage

// ===== rtl/core/i2cbr_cfg_regs.sv =====
// Configuration registers of the I2C bus recovery sequencer.
// Depends on i2cbr_pkg.
`timescale 1ns / 1ps

module i2cbr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [i2cbr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [i2cbr_pkg::CfgDataW-1:0] cfg_data_i,
  output i2cbr_pkg::cfg_t               cfg_o
);
  import i2cbr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD: cfg_d.half_period = cfg_data_i;
        CFG_REQ_HIGH:    cfg_d.req_high    = cfg_data_i[CountW-1:0];
        CFG_SETTLE:      cfg_d.settle      = cfg_data_i;
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HalfPeriodReset;
      cfg_q.req_high    <= ReqHighReset;
      cfg_q.settle      <= SettleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/i2cbr_seq.sv =====
// Recovery phase machine: phase, step timer and high-run counter, with the
// next-state logic and pin/status decode for one beat. Depends on i2cbr_pkg.
`timescale 1ns / 1ps

module i2cbr_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               op_i,
  input  logic               sda_level_i,
  input  i2cbr_pkg::cfg_t    cfg_i,
  output i2cbr_pkg::result_t result_o
);
  import i2cbr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [CountW-1:0] run_q, run_d;
  logic [TimerW-1:0] timer_inc;
  logic [TimerW-1:0] limit;
  logic              step_end;
  logic [TimerW-1:0] timer_step;
  result_t           res;

  assign timer_inc  = timer_q + {{(TimerW-1){1'b0}}, 1'b1};
  assign limit      = (phase_q == PH_SETTLE) ? cfg_i.settle : cfg_i.half_period;
  assign step_end   = (timer_inc >= limit);
  assign timer_step = step_end ? '0 : timer_inc;

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    run_d    = run_q;
    res.done = 1'b0;
    if (advance_i) begin
      if (op_i == OP_START) begin
        phase_d = PH_HOLD;
        timer_d = '0;
        run_d   = '0;
      end else begin
        unique case (phase_q)
          PH_HOLD, PH_UNLK_LO: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = sda_level_i ? PH_STOP1_A : PH_UNLK_HI;
            end
          end
          PH_UNLK_HI: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_UNLK_LO;
            end
          end
          PH_STOP1_A: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_STOP1_B;
            end
          end
          PH_STOP1_B: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_CLK_HI;
            end
          end
          PH_CLK_HI: begin
            timer_d = timer_step;
            if (step_end) begin
              if (!sda_level_i) begin
                run_d = '0;
              end else if (run_q != CountMax) begin
                run_d = run_q + {{(CountW-1){1'b0}}, 1'b1};
              end
              phase_d = PH_CLK_LO;
            end
          end
          PH_CLK_LO: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = (run_q >= cfg_i.req_high) ? PH_STOP2_A : PH_CLK_HI;
            end
          end
          PH_STOP2_A: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_STOP2_B;
            end
          end
          PH_STOP2_B: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_STOP2_C;
            end
          end
          PH_STOP2_C: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            timer_d = timer_step;
            if (step_end) begin
              phase_d  = PH_READY;
              res.done = 1'b1;
            end
          end
          PH_READY: begin
            phase_d = PH_READY;
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end

    res.scl_released       = 1'b1;
    res.sda_released       = 1'b1;
    res.pins_to_controller = 1'b0;
    res.busy               = 1'b1;
    unique case (phase_d)
      PH_HOLD, PH_UNLK_LO, PH_CLK_LO: res.scl_released = 1'b0;
      PH_STOP1_A, PH_STOP2_B:         res.sda_released = 1'b0;
      PH_STOP2_A: begin
        res.scl_released = 1'b0;
        res.sda_released = 1'b0;
      end
      PH_UNLK_HI, PH_STOP1_B, PH_CLK_HI, PH_STOP2_C: res.busy = 1'b1;
      PH_SETTLE: res.pins_to_controller = 1'b1;
      PH_READY: begin
        res.pins_to_controller = 1'b1;
        res.busy               = 1'b0;
      end
      default: res.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      run_q   <= run_d;
    end
  end

  assign result_o = res;

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && op_i == OP_START) |=> (phase_q == PH_HOLD && timer_q == '0 && run_q == '0))
    else $error("start did not restart the sequence");

  a_ready_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_READY && !(advance_i && op_i == OP_START)) |=> (phase_q == PH_READY))
    else $error("finished sequence left its end phase without a start");

  a_done_ends_settle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> (phase_q == PH_SETTLE && phase_d == PH_READY && advance_i))
    else $error("done raised outside the end of the settle wait");

  a_state_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(phase_q) && $stable(timer_q) && $stable(run_q)))
    else $error("sequencer state moved without a beat");

endmodule

// ===== rtl/core/i2c_bus_recovery_sequencer.sv =====
// I2C bus recovery sequencer. Each input beat is one time tick or a start
// command carrying an SDA sample, and it gives one result beat with the pin
// drive and status. One input beat is taken every clock cycle; its result is
// ready in the output register on the next cycle, and the only limit on the
// rate is that single output register, which takes a new beat whenever it is
// empty or being emptied in the same cycle. Configuration writes are
// registered and should be made only while no result is outstanding.
// Depends on i2cbr_pkg, i2cbr_cfg_regs and i2cbr_seq.
`timescale 1ns / 1ps

module i2c_bus_recovery_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2cbr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cbr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic                           sda_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           scl_released_o,
  output logic                           sda_released_o,
  output logic                           pins_to_controller_o,
  output logic                           busy_res_o,
  output logic                           done_res_o
);
  import i2cbr_pkg::*;

  cfg_t    cfg;
  result_t res_d, res_q;
  logic    out_valid_q, out_valid_d;
  logic    accept;

  assign cfg_ready_o = 1'b1;

  i2cbr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  i2cbr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (accept),
    .op_i       (op_i),
    .sda_level_i(sda_level_i),
    .cfg_i      (cfg),
    .result_o   (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign scl_released_o       = res_q.scl_released;
  assign sda_released_o       = res_q.sda_released;
  assign pins_to_controller_o = res_q.pins_to_controller;
  assign busy_res_o           = res_q.busy;
  assign done_res_o           = res_q.done;

endmodule

// ===== dv/i2cbr_checker.sv =====
// Scoreboard for the I2C bus recovery sequencer: watches the configuration, input and
// result channels, predicts the pin drive and status for every input beat and compares.
// Depends on i2cbr_pkg.
`timescale 1ns / 1ps

module i2cbr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [i2cbr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cbr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           op_i,
  input  logic                           sda_level_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           scl_released_i,
  input  logic                           sda_released_i,
  input  logic                           pins_to_controller_i,
  input  logic                           busy_res_i,
  input  logic                           done_res_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import i2cbr_pkg::*;

  cfg_t              model_cfg;
  phase_e            model_phase;
  logic [TimerW-1:0] model_timer;
  logic [CountW-1:0] model_high_run;
  result_t           pin_status_q[$];

  function automatic logic step_elapsed(input logic [TimerW-1:0] limit);
    model_timer = model_timer + TimerW'(1);
    if (model_timer >= limit) begin
      model_timer = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t next_pin_status(input logic op, input logic sda);
    result_t r;
    r.scl_released       = 1'b1;
    r.sda_released       = 1'b1;
    r.pins_to_controller = 1'b0;
    r.busy               = 1'b1;
    r.done               = 1'b0;
    if (op == OP_START) begin
      model_phase    = PH_HOLD;
      model_timer    = '0;
      model_high_run = '0;
    end else begin
      case (model_phase)
        PH_HOLD, PH_UNLK_LO: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = sda ? PH_STOP1_A : PH_UNLK_HI;
        end
        PH_UNLK_HI: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_UNLK_LO;
        end
        PH_STOP1_A: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_STOP1_B;
        end
        PH_STOP1_B: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_CLK_HI;
        end
        PH_CLK_HI: begin
          if (step_elapsed(model_cfg.half_period)) begin
            if (!sda) begin
              model_high_run = '0;
            end else if (model_high_run != CountMax) begin
              model_high_run = model_high_run + CountW'(1);
            end
            model_phase = PH_CLK_LO;
          end
        end
        PH_CLK_LO: begin
          if (step_elapsed(model_cfg.half_period)) begin
            model_phase = (model_high_run >= model_cfg.req_high) ? PH_STOP2_A : PH_CLK_HI;
          end
        end
        PH_STOP2_A: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_STOP2_B;
        end
        PH_STOP2_B: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_STOP2_C;
        end
        PH_STOP2_C: begin
          if (step_elapsed(model_cfg.half_period)) model_phase = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (step_elapsed(model_cfg.settle)) begin
            model_phase = PH_READY;
            r.done      = 1'b1;
          end
        end
        PH_READY: ;
        default: begin
          model_phase = PH_IDLE;
          model_timer = '0;
        end
      endcase
    end

    case (model_phase)
      PH_HOLD, PH_UNLK_LO, PH_CLK_LO: r.scl_released = 1'b0;
      PH_STOP1_A, PH_STOP2_B: r.sda_released = 1'b0;
      PH_STOP2_A: begin
        r.scl_released = 1'b0;
        r.sda_released = 1'b0;
      end
      PH_SETTLE: r.pins_to_controller = 1'b1;
      PH_READY: begin
        r.pins_to_controller = 1'b1;
        r.busy               = 1'b0;
      end
      PH_UNLK_HI, PH_STOP1_B, PH_CLK_HI, PH_STOP2_C: ;
      default: r.busy = 1'b0;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    if (!rst_ni) begin
      model_cfg.half_period = HalfPeriodReset;
      model_cfg.req_high    = ReqHighReset;
      model_cfg.settle      = SettleReset;
      model_phase           = PH_IDLE;
      model_timer           = '0;
      model_high_run        = '0;
      fail_count_o          = 0;
      pin_status_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HALF_PERIOD: model_cfg.half_period = cfg_data_i;
          CFG_REQ_HIGH:    model_cfg.req_high = cfg_data_i[CountW-1:0];
          CFG_SETTLE:      model_cfg.settle = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pin_status_q.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          fail_count_o++;
        end else begin
          exp_r = pin_status_q.pop_front();
          check_field("scl_released", exp_r.scl_released, scl_released_i);
          check_field("sda_released", exp_r.sda_released, sda_released_i);
          check_field("pins_to_controller", exp_r.pins_to_controller, pins_to_controller_i);
          check_field("busy_res", exp_r.busy, busy_res_i);
          check_field("done_res", exp_r.done, done_res_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        pin_status_q.push_back(next_pin_status(op_i, sda_level_i));
      end
    end
    pending_o = pin_status_q.size();
  end

endmodule

// ===== dv/tb_i2c_bus_recovery_sequencer.sv =====
// Top of the I2C bus recovery sequencer testbench: clock, reset, register writes, tick and
// start beats with random idling and output stalls; the checker's failure count decides.
// Depends on i2cbr_pkg, i2c_bus_recovery_sequencer and i2cbr_checker.
`timescale 1ns / 1ps

module tb_i2c_bus_recovery_sequencer;
  import i2cbr_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused  = 2'd3;
  localparam int unsigned        PhaseBeats = 170;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                op_i        = 1'b0;
  logic                sda_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                scl_released_o;
  logic                sda_released_o;
  logic                pins_to_controller_o;
  logic                busy_res_o;
  logic                done_res_o;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       sender_idle_pct    = 0;
  int unsigned       receiver_stall_pct = 0;
  int unsigned       phase_beats        = 0;
  logic [TimerW-1:0] cur_half           = HalfPeriodReset;
  logic [CountW-1:0] cur_req            = ReqHighReset;
  logic [TimerW-1:0] cur_settle         = SettleReset;

  i2c_bus_recovery_sequencer dut (.*);

  i2cbr_checker checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_i          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .op_i                 (op_i),
    .sda_level_i          (sda_level_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .scl_released_i       (scl_released_o),
    .sda_released_i       (sda_released_o),
    .pins_to_controller_i (pins_to_controller_o),
    .busy_res_i           (busy_res_o),
    .done_res_i           (done_res_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_beat(input logic op, input logic sda);
    if ($urandom_range(199) == 0) begin
      wait_drained();
    end else if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    sda_level_i <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    phase_beats++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [TimerW-1:0] half, input logic [CountW-1:0] req,
                              input logic [TimerW-1:0] settle);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_REQ_HIGH, {8'($urandom), req});
    write_reg(CfgUnused, 16'($urandom));
    write_reg(CFG_SETTLE, settle);
    cfg_valid_i <= 1'b0;
    cur_half   = half;
    cur_req    = req;
    cur_settle = settle;
  endtask

  // SDA is held low for a while at the start so that the unlock loop pulses, then it is
  // mostly high so that the high run can build up, with the odd low beat to break it.
  task automatic run_recovery();
    int unsigned half;
    int unsigned req;
    int unsigned low_ticks;
    int unsigned span;
    half      = (cur_half == '0) ? 1 : 32'(cur_half);
    req       = (cur_req == '0) ? 1 : 32'(cur_req);
    low_ticks = $urandom_range(3 * half);
    span      = half * (6 * req + 16) + 32'(cur_settle) + $urandom_range(6);
    if (span > 400) span = $urandom_range(80, 20);
    if ($urandom_range(7) == 0) span = $urandom_range(span);
    repeat ($urandom_range(2)) send_beat(OP_TICK, 1'($urandom_range(1)));
    send_beat(OP_START, 1'($urandom_range(1)));
    for (int unsigned n = 0; n < span; n++) begin
      send_beat(OP_TICK, (n < low_ticks) ? 1'b0 : ($urandom_range(9) != 0));
    end
  endtask

  task automatic random_phase(input logic [TimerW-1:0] half, input logic [CountW-1:0] req,
                              input logic [TimerW-1:0] settle, input int unsigned send_idle,
                              input int unsigned recv_stall);
    program_regs(half, req, settle);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    phase_beats        = 0;
    while (phase_beats < PhaseBeats) run_recovery();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_START, 1'b0);
    repeat (5) send_beat(OP_TICK, 1'b0);
    send_beat(OP_START, 1'b1);
    repeat (5) send_beat(OP_TICK, 1'b1);
    wait_drained();

    // Zero half period, zero required count and zero settle time, run to completion.
    program_regs('0, '0, '0);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b0);
    repeat (11) send_beat(OP_TICK, 1'b1);
    wait_drained();

    random_phase(16'd1, 8'd1, 16'd0, 0, 0);
    random_phase(16'd0, 8'd0, 16'd1, 48, 0);
    random_phase(16'd2, 8'd3, 16'd4, 0, 48);
    random_phase(16'd3, 8'd2, 16'd6, 12, 12);
    random_phase(16'hFFFF, 8'hFF, 16'hFFFF, 0, 0);
    random_phase(16'd1, 8'd4, 16'd2, 48, 0);

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("i2c_bus_recovery_sequencer verification clean");
    end else begin
      $display("i2c_bus_recovery_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("i2c_bus_recovery_sequencer verification failed");
    $finish;
  end

endmodule
